// ----- rtl/core/cir_pkg.sv -----
// cir_pkg: shared constants, codes and types of the client id registry
// depends on: nothing
`timescale 1ns / 1ps

package cir_pkg;

  // table geometry
  localparam int TABLE_SIZE = 64;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

  // field widths
  localparam int ID_W    = 31;
  localparam int ENTRY_W = ID_W + 1;   // {family, handle}

  // configuration port
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int REG_IDX_LSB = 2;
  localparam logic REG_BASE_ID = 1'b0;

  // ids must stay below the largest 31-bit value
  localparam logic [ID_W:0] ID_LIMIT = {1'b0, {ID_W{1'b1}}};

  typedef logic [2:0] kind_t;
  localparam kind_t KIND_ADD       = 3'd0;
  localparam kind_t KIND_LOOKUP_ID = 3'd1;
  localparam kind_t KIND_LOOKUP_H  = 3'd2;
  localparam kind_t KIND_REMOVE_H  = 3'd3;
  localparam kind_t KIND_REMOVE_ID = 3'd4;
  localparam kind_t KIND_LIST      = 3'd5;

  typedef logic [1:0] status_t;
  localparam status_t STAT_OK   = 2'd0;
  localparam status_t STAT_FULL = 2'd1;
  localparam status_t STAT_MISS = 2'd2;

  typedef struct packed {
    status_t         status;
    logic [ID_W-1:0] result_id;
    logic [ID_W-1:0] result_handle;
    logic            result_family;
    logic            last_item;
  } result_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } ram_req_t;

endpackage

// ----- rtl/core/cir_ram.sv -----
// cir_ram: generic single-write, single-read memory with registered read data
// depends on: nothing
`timescale 1ns / 1ps

module cir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/cir_cfg.sv -----
// cir_cfg: apb-style register file holding the allocator base id
// depends on: cir_pkg
`timescale 1ns / 1ps

module cir_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cir_pkg::PADDR_W-1:0]  paddr,
  input  logic [cir_pkg::PDATA_W-1:0]  pwdata,
  output logic [cir_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [cir_pkg::ID_W-1:0]     base_id
);
  import cir_pkg::*;

  logic [ID_W-1:0] base_id_r;
  logic            reg_idx;
  logic            wr_en;

  assign reg_idx = paddr[REG_IDX_LSB];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_id_r <= '0;
    end else if (wr_en && (reg_idx == REG_BASE_ID)) begin
      base_id_r <= pwdata[ID_W-1:0];
    end
  end

  // low address bits are ignored, registers are word aligned
  assign prdata  = (reg_idx == REG_BASE_ID) ? PDATA_W'(base_id_r) : '0;
  assign base_id = base_id_r;

endmodule

// ----- rtl/core/cir_engine.sv -----
// cir_engine: command sequencer, valid bits, entry count and output register
// depends on: cir_pkg; drives the entry memory through a ram_req_t
`timescale 1ns / 1ps

module cir_engine (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [cir_pkg::ID_W-1:0]     base_id,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  cir_pkg::kind_t               in_kind,
  input  logic [cir_pkg::ID_W-1:0]     in_client_id,
  input  logic [cir_pkg::ID_W-1:0]     in_os_handle,
  input  logic                         in_protocol_family,
  output logic                         out_valid,
  input  logic                         out_stall,
  output cir_pkg::result_t             out_res,
  output cir_pkg::ram_req_t            ram_req,
  input  logic [cir_pkg::ENTRY_W-1:0]  ram_rdata
);
  import cir_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_ADD      = 3'd1;
  localparam logic [2:0] ST_ID_RD    = 3'd2;
  localparam logic [2:0] ST_ID_CHK   = 3'd3;
  localparam logic [2:0] ST_SCAN_RD  = 3'd4;
  localparam logic [2:0] ST_SCAN_CHK = 3'd5;
  localparam logic [2:0] ST_MISS     = 3'd6;

  logic [2:0]            state_r, state_nxt;
  kind_t                 kind_r, kind_nxt;
  logic [ID_W-1:0]       cid_r, cid_nxt;
  logic [ID_W-1:0]       handle_r, handle_nxt;
  logic                  fam_r, fam_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic                  found_r, found_nxt;
  logic [CNT_W-1:0]      list_n_r, list_n_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [TABLE_SIZE-1:0] valid_r, valid_nxt;
  logic                  out_valid_r;
  result_t               out_res_r;

  logic            accept;
  logic            out_free;
  logic            emit;
  result_t         e_res;
  logic [ID_W:0]   id_sum;
  logic [ID_W:0]   id_off;
  logic            in_win;
  logic [IDX_W-1:0] slot;
  logic [ID_W-1:0] ent_handle;
  logic            ent_fam;
  logic            idx_last;
  logic            scan_hit;
  logic            list_last;

  assign in_stall   = (state_r != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;

  assign id_sum     = {1'b0, base_id} + (ID_W + 1)'(idx_r);
  assign id_off     = {1'b0, cid_r} - {1'b0, base_id};
  assign in_win     = (cid_r >= base_id) && (id_off < (ID_W + 1)'(TABLE_SIZE));
  assign slot       = id_off[IDX_W-1:0];
  assign ent_handle = ram_rdata[ID_W-1:0];
  assign ent_fam    = ram_rdata[ID_W];
  assign idx_last   = (idx_r == IDX_W'(TABLE_SIZE - 1));
  assign scan_hit   = valid_r[idx_r] &&
                      ((kind_r == KIND_LIST) ||
                       ((ent_handle == handle_r) && (ent_fam == fam_r)));
  assign list_last  = ((list_n_r + CNT_W'(1)) == cnt_r);

  always_comb begin
    state_nxt  = state_r;
    kind_nxt   = kind_r;
    cid_nxt    = cid_r;
    handle_nxt = handle_r;
    fam_nxt    = fam_r;
    idx_nxt    = idx_r;
    found_nxt  = found_r;
    list_n_nxt = list_n_r;
    cnt_nxt    = cnt_r;
    valid_nxt  = valid_r;
    emit       = 1'b0;
    e_res      = '0;
    ram_req    = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          kind_nxt   = in_kind;
          cid_nxt    = in_client_id;
          handle_nxt = in_os_handle;
          fam_nxt    = in_protocol_family;
          idx_nxt    = '0;
          list_n_nxt = '0;
          unique case (in_kind) inside
            KIND_ADD:                       state_nxt = ST_ADD;
            KIND_LOOKUP_ID, KIND_REMOVE_ID: state_nxt = ST_ID_RD;
            KIND_LOOKUP_H, KIND_REMOVE_H:   state_nxt = ST_SCAN_RD;
            KIND_LIST:  state_nxt = (cnt_r == '0) ? ST_MISS : ST_SCAN_RD;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end

      ST_ADD: begin
        if ((id_sum >= ID_LIMIT) || (valid_r[idx_r] && idx_last)) begin
          // no usable slot left
          if (out_free) begin
            emit             = 1'b1;
            e_res.status     = STAT_FULL;
            e_res.last_item  = 1'b1;
            state_nxt        = ST_IDLE;
          end
        end else if (!valid_r[idx_r]) begin
          if (out_free) begin
            ram_req.we          = 1'b1;
            ram_req.waddr       = idx_r;
            ram_req.wdata       = {fam_r, handle_r};
            valid_nxt[idx_r]    = 1'b1;
            cnt_nxt             = cnt_r + CNT_W'(1);
            emit                = 1'b1;
            e_res.status        = STAT_OK;
            e_res.result_id     = id_sum[ID_W-1:0];
            e_res.result_handle = handle_r;
            e_res.result_family = fam_r;
            e_res.last_item     = 1'b1;
            state_nxt           = ST_IDLE;
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      ST_ID_RD: begin
        idx_nxt   = slot;
        found_nxt = in_win && valid_r[slot];
        if (kind_r == KIND_REMOVE_ID) begin
          if (in_win && valid_r[slot]) begin
            valid_nxt[slot] = 1'b0;
            cnt_nxt         = cnt_r - CNT_W'(1);
          end
          state_nxt = ST_IDLE;
        end else begin
          ram_req.re    = 1'b1;
          ram_req.raddr = slot;
          state_nxt     = ST_ID_CHK;
        end
      end

      ST_ID_CHK: begin
        if (out_free) begin
          emit            = 1'b1;
          e_res.last_item = 1'b1;
          if (found_r) begin
            e_res.status        = STAT_OK;
            e_res.result_id     = cid_r;
            e_res.result_handle = ent_handle;
            e_res.result_family = ent_fam;
          end else begin
            e_res.status = STAT_MISS;
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_SCAN_RD: begin
        ram_req.re    = 1'b1;
        ram_req.raddr = idx_r;
        state_nxt     = ST_SCAN_CHK;
      end

      ST_SCAN_CHK: begin
        if (scan_hit) begin
          unique case (kind_r) inside
            KIND_REMOVE_H: begin
              valid_nxt[idx_r] = 1'b1 ^ valid_r[idx_r];
              cnt_nxt          = cnt_r - CNT_W'(1);
              state_nxt        = ST_IDLE;
            end
            KIND_LOOKUP_H, KIND_LIST: begin
              if (out_free) begin
                emit                = 1'b1;
                e_res.status        = STAT_OK;
                e_res.result_id     = id_sum[ID_W-1:0];
                e_res.result_handle = ent_handle;
                e_res.result_family = ent_fam;
                e_res.last_item     = (kind_r == KIND_LOOKUP_H) || list_last;
                list_n_nxt          = list_n_r + CNT_W'(1);
                if (e_res.last_item || idx_last) begin
                  state_nxt = ST_IDLE;
                end else begin
                  idx_nxt   = idx_r + IDX_W'(1);
                  state_nxt = ST_SCAN_RD;
                end
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end else if (idx_last) begin
          state_nxt = (kind_r == KIND_LOOKUP_H) ? ST_MISS : ST_IDLE;
        end else begin
          idx_nxt   = idx_r + IDX_W'(1);
          state_nxt = ST_SCAN_RD;
        end
      end

      ST_MISS: begin
        if (out_free) begin
          emit            = 1'b1;
          e_res.status    = STAT_MISS;
          e_res.last_item = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      cnt_r   <= cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    cid_r    <= cid_nxt;
    handle_r <= handle_nxt;
    fam_r    <= fam_nxt;
    idx_r    <= idx_nxt;
    found_r  <= found_nxt;
    list_n_r <= list_n_nxt;
    if (emit) begin
      out_res_r <= e_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

// ----- rtl/core/client_id_registry.sv -----
// client_id_registry: top level of the client id table
// depends on: cir_pkg, cir_cfg, cir_engine, cir_ram
`timescale 1ns / 1ps

// The registry keeps a table of cir_pkg::TABLE_SIZE entries; slot i stands
// for client id base_id + i and holds a connection handle and a protocol
// family. One item is worked at a time: in_stall is high from the cycle
// after an item is accepted until its work is done, and a finished result
// waits in an output register so the next item can be taken while it is
// still stalled. The sequencer steps one table slot at a time over an entry
// memory with registered read data: add steps over occupied slots to the
// first free one; remove by id needs no memory read, lookup by id reads its
// slot once; lookup and remove by handle scan slots up to the lowest match;
// list scans slots up to the last valid entry, and on an empty table reports
// a miss without a scan. While a result waits on out_stall, the sequencer
// holds before emitting the next one. Valid marks reset to empty at once, so
// no clearing pass follows reset. base_id is written through the apb-style
// port at byte address 0 and must only change while the block is idle.
module client_id_registry (
  input  logic                         clk,
  input  logic                         rst_n,
  // command items
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   in_kind,
  input  logic [cir_pkg::ID_W-1:0]     in_client_id,
  input  logic [cir_pkg::ID_W-1:0]     in_os_handle,
  input  logic                         in_protocol_family,
  // result items
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   out_status,
  output logic [cir_pkg::ID_W-1:0]     out_result_id,
  output logic [cir_pkg::ID_W-1:0]     out_result_handle,
  output logic                         out_result_family,
  output logic                         out_last_item,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cir_pkg::PADDR_W-1:0]  paddr,
  input  logic [cir_pkg::PDATA_W-1:0]  pwdata,
  output logic [cir_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import cir_pkg::*;

  logic [ID_W-1:0]    base_id;
  result_t            res;
  ram_req_t           ram_req;
  logic [ENTRY_W-1:0] ram_rdata;

  // register file: base id of the allocation window
  cir_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .base_id (base_id)
  );

  // sequencer with valid marks, entry count and the output register
  cir_engine u_engine (
    .clk                (clk),
    .rst_n              (rst_n),
    .base_id            (base_id),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (kind_t'(in_kind)),
    .in_client_id       (in_client_id),
    .in_os_handle       (in_os_handle),
    .in_protocol_family (in_protocol_family),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_res            (res),
    .ram_req            (ram_req),
    .ram_rdata          (ram_rdata)
  );

  // entry memory: {family, handle} per slot, read data only used behind a valid mark
  cir_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SIZE)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // split the result item onto its ports
  assign out_status        = res.status;
  assign out_result_id     = res.result_id;
  assign out_result_handle = res.result_handle;
  assign out_result_family = res.result_family;
  assign out_last_item     = res.last_item;

endmodule

// ----- rtl/core/cir_checker.sv -----
// cir_checker: port-level assertions for the client id registry, with bind
// depends on: cir_pkg, client_id_registry
`timescale 1ns / 1ps

module cir_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [2:0]                   in_kind,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [1:0]                   out_status
);
  import cir_pkg::*;

  // a result waiting on a stalled receiver is not dropped
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // reset empties the output register
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // a remove produces no result
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid &&
    (in_kind == KIND_REMOVE_H || in_kind == KIND_REMOVE_ID) |=> !out_valid)
    else $error("remove produced a result");

  // a lookup by id keeps the block busy while the entry is read
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_kind == KIND_LOOKUP_ID |=> in_stall)
    else $error("item taken during lookup");

  // status code three is never produced
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("bad status code");

endmodule

bind client_id_registry cir_checker u_cir_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_kind    (in_kind),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_status (out_status)
);

// ----- dv/client_id_registry_tb.sv -----
// client_id_registry_tb: self-checking bench for the client id table
// depends on: cir_pkg, client_id_registry
`timescale 1ns / 1ps

module client_id_registry_tb;
  import cir_pkg::*;

  // bench timing
  localparam int CLK_HALF_NS   = 10;
  localparam int RESET_CYCLES  = 4;
  localparam int TIME_LIMIT_NS = 40_000_000;
  // worst remove by handle scans the whole table
  localparam int DRAIN_CYCLES  = 2 * TABLE_SIZE + 40;
  localparam int LONG_HOLD     = 400;
  localparam int ITEMS_PER_PHASE = 65;
  localparam int NUM_PHASES      = 4;
  localparam int MAX_PRINTED     = 40;

  // highest base id the allocator may be given
  localparam logic [ID_W-1:0] BASE_ID_TOP = 31'd2147483583;
  localparam logic [ID_W-1:0] ALL_ONES    = {ID_W{1'b1}};
  localparam logic [ID_W-1:0] ZERO_31     = '0;
  localparam logic [PADDR_W-1:0] BASE_ID_ADDR = PADDR_W'(4 * int'(REG_BASE_ID));

  // item codes the block must ignore
  localparam kind_t KIND_SPARE6 = 3'd6;
  localparam kind_t KIND_SPARE7 = 3'd7;

  typedef struct packed {
    kind_t           kind;
    logic [ID_W-1:0] client_id;
    logic [ID_W-1:0] os_handle;
    logic            family;
  } cmd_t;

  // one directed step: the command, and a hand-written result where it is obvious
  typedef struct packed {
    cmd_t    cmd;
    logic    typed;
    result_t want;
  } step_t;

  localparam result_t LONE_MISS = '{STAT_MISS, 31'd0, 31'd0, 1'b0, 1'b1};
  localparam result_t NO_WANT   = '0;

  // directed part, base id 0 straight after reset
  localparam step_t DIRECTED_STEPS [0:23] = '{
    // empty table: list, both lookups miss, removes are ignored
    '{'{KIND_LIST,      ZERO_31,  ZERO_31,  1'b0}, 1'b1, LONE_MISS},
    '{'{KIND_LOOKUP_ID, ZERO_31,  ZERO_31,  1'b0}, 1'b1, LONE_MISS},
    '{'{KIND_LOOKUP_H,  ZERO_31,  ALL_ONES, 1'b1}, 1'b1, LONE_MISS},
    '{'{KIND_REMOVE_ID, ZERO_31,  ZERO_31,  1'b0}, 1'b0, NO_WANT},
    '{'{KIND_REMOVE_H,  ZERO_31,  ZERO_31,  1'b0}, 1'b0, NO_WANT},
    // adds fill slots from the bottom, a duplicate pair takes a further id
    '{'{KIND_ADD, ALL_ONES, ALL_ONES, 1'b1}, 1'b1, '{STAT_OK, 31'd0, ALL_ONES, 1'b1, 1'b1}},
    '{'{KIND_ADD, ZERO_31,  ZERO_31,  1'b0}, 1'b1, '{STAT_OK, 31'd1, ZERO_31, 1'b0, 1'b1}},
    '{'{KIND_ADD, ZERO_31,  ALL_ONES, 1'b1}, 1'b1, '{STAT_OK, 31'd2, ALL_ONES, 1'b1, 1'b1}},
    '{'{KIND_ADD, ZERO_31,  ALL_ONES, 1'b0}, 1'b1, '{STAT_OK, 31'd3, ALL_ONES, 1'b0, 1'b1}},
    // reverse lookup returns the lowest match, family must agree
    '{'{KIND_LOOKUP_H,  ZERO_31,  ALL_ONES, 1'b1}, 1'b0, NO_WANT},
    '{'{KIND_LOOKUP_H,  ZERO_31,  ALL_ONES, 1'b0}, 1'b0, NO_WANT},
    '{'{KIND_LOOKUP_ID, 31'd2,    ZERO_31,  1'b0}, 1'b0, NO_WANT},
    // ids outside the table window
    '{'{KIND_LOOKUP_ID, ALL_ONES, ZERO_31,  1'b0}, 1'b1, LONE_MISS},
    '{'{KIND_REMOVE_ID, 31'd64,   ZERO_31,  1'b0}, 1'b0, NO_WANT},
    // remove of a duplicated pair drops only the lowest one
    '{'{KIND_REMOVE_H,  ZERO_31,  ALL_ONES, 1'b1}, 1'b0, NO_WANT},
    '{'{KIND_LOOKUP_H,  ZERO_31,  ALL_ONES, 1'b1}, 1'b0, NO_WANT},
    // unused codes change nothing
    '{'{KIND_SPARE6,    ALL_ONES, ALL_ONES, 1'b1}, 1'b0, NO_WANT},
    '{'{KIND_SPARE7,    ZERO_31,  ZERO_31,  1'b0}, 1'b0, NO_WANT},
    // the freed slot 0 is reused
    '{'{KIND_ADD,       ZERO_31,  31'h5555_5555, 1'b0}, 1'b0, NO_WANT},
    '{'{KIND_REMOVE_ID, 31'd1,    ZERO_31,  1'b0}, 1'b0, NO_WANT},
    '{'{KIND_LOOKUP_ID, 31'd1,    ZERO_31,  1'b0}, 1'b1, LONE_MISS},
    '{'{KIND_LIST,      ZERO_31,  ZERO_31,  1'b0}, 1'b0, NO_WANT},
    // removing a pair that is already gone is silent
    '{'{KIND_REMOVE_H,  ZERO_31,  ZERO_31,  1'b0}, 1'b0, NO_WANT},
    '{'{KIND_LIST,      ALL_ONES, ALL_ONES, 1'b1}, 1'b0, NO_WANT}
  };

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [2:0]          in_kind;
  logic [ID_W-1:0]     in_client_id;
  logic [ID_W-1:0]     in_os_handle;
  logic                in_protocol_family;
  logic                out_valid;
  logic                out_stall;
  logic [1:0]          out_status;
  logic [ID_W-1:0]     out_result_id;
  logic [ID_W-1:0]     out_result_handle;
  logic                out_result_family;
  logic                out_last_item;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // mirror of the table: base id and per-slot contents
  logic [ID_W-1:0] base_now;
  bit              slot_used [TABLE_SIZE];
  logic [ID_W-1:0] slot_handle [TABLE_SIZE];
  logic            slot_family [TABLE_SIZE];

  // results still owed by the block, oldest first
  result_t         pending_results [$];
  logic [ID_W-1:0] handle_pool [8];

  int error_count;
  int results_seen;
  bit tx_idle_on;
  bit rx_idle_on;
  // toggled by the stimulus to ask the result side for one long hold
  bit hold_request;

  client_id_registry dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_client_id       (in_client_id),
    .in_os_handle       (in_os_handle),
    .in_protocol_family (in_protocol_family),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_result_id      (out_result_id),
    .out_result_handle  (out_result_handle),
    .out_result_family  (out_result_family),
    .out_last_item      (out_last_item),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(TIME_LIMIT_NS);
    $display("** client_id_registry: FAILED **");
    $finish;
  end

  task automatic log_mismatch(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want)
      log_mismatch($sformatf("result %0d %s: got %0h, want %0h",
                             results_seen, name, got, want));
  endtask

  function automatic void owe_result(status_t st, logic [ID_W-1:0] id,
                                     logic [ID_W-1:0] handle, logic fam, logic last);
    result_t r;
    r = '{st, id, handle, fam, last};
    pending_results.push_back(r);
  endfunction

  // slot that an id maps to in the current window, or -1
  function automatic int slot_for_id(logic [ID_W-1:0] cid);
    logic [31:0] offset;
    if (cid < base_now) return -1;
    offset = {1'b0, cid} - {1'b0, base_now};
    return (offset >= TABLE_SIZE) ? -1 : int'(offset);
  endfunction

  // lowest occupied slot holding this handle and family, or -1
  function automatic int slot_for_pair(logic [ID_W-1:0] handle, logic fam);
    for (int i = 0; i < TABLE_SIZE; i++)
      if (slot_used[i] && slot_handle[i] == handle && slot_family[i] == fam) return i;
    return -1;
  endfunction

  function automatic int slots_in_use();
    int n;
    n = 0;
    for (int i = 0; i < TABLE_SIZE; i++) n += int'(slot_used[i]);
    return n;
  endfunction

  // apply one accepted command to the mirror and queue what it must produce
  function automatic void apply_command(cmd_t c);
    int          slot;
    int          listed;
    logic [31:0] id;
    slot   = -1;
    listed = 0;
    case (c.kind)
      KIND_ADD: begin
        // lowest free slot whose id stays below the ceiling
        for (int i = 0; i < TABLE_SIZE; i++) begin
          id = {1'b0, base_now} + 32'(i);
          if (id >= ID_LIMIT) break;
          if (!slot_used[i]) begin
            slot = i;
            break;
          end
        end
        if (slot >= 0) begin
          slot_used[slot]   = 1'b1;
          slot_handle[slot] = c.os_handle;
          slot_family[slot] = c.family;
          owe_result(STAT_OK, id[ID_W-1:0], c.os_handle, c.family, 1'b1);
        end else begin
          owe_result(STAT_FULL, '0, '0, 1'b0, 1'b1);
        end
      end
      KIND_LOOKUP_ID, KIND_LOOKUP_H: begin
        slot = (c.kind == KIND_LOOKUP_ID) ? slot_for_id(c.client_id)
                                          : slot_for_pair(c.os_handle, c.family);
        if (slot >= 0 && slot_used[slot])
          owe_result(STAT_OK, base_now + ID_W'(slot), slot_handle[slot],
                     slot_family[slot], 1'b1);
        else
          owe_result(STAT_MISS, '0, '0, 1'b0, 1'b1);
      end
      KIND_REMOVE_ID, KIND_REMOVE_H: begin
        slot = (c.kind == KIND_REMOVE_ID) ? slot_for_id(c.client_id)
                                          : slot_for_pair(c.os_handle, c.family);
        if (slot >= 0) slot_used[slot] = 1'b0;
      end
      KIND_LIST: begin
        for (int i = 0; i < TABLE_SIZE; i++) begin
          if (slot_used[i]) begin
            owe_result(STAT_OK, base_now + ID_W'(i), slot_handle[i], slot_family[i], 1'b0);
            listed++;
          end
        end
        if (listed == 0) owe_result(STAT_MISS, '0, '0, 1'b0, 1'b1);
        else pending_results[pending_results.size() - 1].last_item = 1'b1;
      end
      default: ;  // spare codes are ignored
    endcase
  endfunction

  // random command, biased toward ids in the window and pairs that are stored
  function automatic cmd_t random_command();
    cmd_t c;
    int   pick;
    int   sub;
    int   s;
    // fields a command does not use still get random bits
    c.kind      = KIND_ADD;
    c.client_id = ID_W'($urandom);
    c.os_handle = ID_W'($urandom);
    c.family    = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      if ($urandom_range(0, 9) < 7) c.os_handle = handle_pool[$urandom_range(0, 7)];
    end else if (pick < 62) begin
      c.kind = (pick < 52) ? KIND_LOOKUP_ID : KIND_REMOVE_ID;
      sub = $urandom_range(0, 19);
      if (sub < 16) c.client_id = base_now + ID_W'($urandom_range(0, TABLE_SIZE - 1));
      else if (sub < 18) c.client_id = base_now + ID_W'($urandom_range(TABLE_SIZE, 80));
      else if (sub == 18) c.client_id = base_now - 31'd1;
    end else if (pick < 80) begin
      c.kind = (pick < 72) ? KIND_LOOKUP_H : KIND_REMOVE_H;
      s = $urandom_range(0, TABLE_SIZE - 1);
      if (slot_used[s] && $urandom_range(0, 9) < 7) begin
        c.os_handle = slot_handle[s];
        c.family    = slot_family[s];
      end else begin
        c.os_handle = handle_pool[$urandom_range(0, 7)];
      end
    end else if (pick < 85) begin
      c.kind = KIND_LIST;
    end else if (pick < 87) begin
      c.kind = $urandom_range(0, 1) ? KIND_SPARE6 : KIND_SPARE7;
    end else begin
      // noise: lookup of an arbitrary id
      c.kind = KIND_LOOKUP_ID;
    end
    return c;
  endfunction

  // add with random content, for filling the table
  function automatic cmd_t random_command_add();
    cmd_t c;
    c.kind      = KIND_ADD;
    c.client_id = ID_W'($urandom);
    c.os_handle = $urandom_range(0, 1) ? handle_pool[$urandom_range(0, 7)] : ID_W'($urandom);
    c.family    = 1'($urandom);
    return c;
  endfunction

  // offer one item, wait for it to be taken, then update the mirror
  task automatic send_item(input cmd_t c, input bit typed, input result_t want);
    int gap;
    int owed_before;
    gap = 0;
    if (tx_idle_on && $urandom_range(0, 99) < 25) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid           <= 1'b1;
    in_kind            <= c.kind;
    in_client_id       <= c.client_id;
    in_os_handle       <= c.os_handle;
    in_protocol_family <= c.family;
    do @(posedge clk); while (in_stall);
    owed_before = pending_results.size();
    apply_command(c);
    // a hand-written result replaces the one just worked out
    if (typed) begin
      while (pending_results.size() > owed_before) void'(pending_results.pop_back());
      pending_results.push_back(want);
    end
  endtask

  // stop offering, let every owed result out, then give slow removes time to finish
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // setup then access cycle; the write lands on the edge with pready high
  task automatic write_base_id(input logic [ID_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= BASE_ID_ADDR;
    pwdata  <= {1'b0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    base_now = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // result side: random stall bursts, plus one long hold on request
  initial begin : result_side
    int burst;
    int hold_left;
    bit hold_seen;
    burst     = 0;
    hold_left = 0;
    hold_seen = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request != hold_seen) begin
        hold_left = LONG_HOLD;
        hold_seen = hold_request;
      end
      if (hold_left > 0) hold_left--;
      else if (burst > 0) burst--;
      else if (rx_idle_on && $urandom_range(0, 99) < 12) burst = $urandom_range(1, 16);
      out_stall <= (hold_left > 0) || (burst > 0);
    end
  end

  // compare every result taken against the oldest owed one
  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_status, out_result_id, out_result_handle, out_result_family, out_last_item};
      if (pending_results.size() == 0) begin
        log_mismatch($sformatf("result %0d arrived with nothing owed: %h",
                               results_seen, got));
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(got.status));
        check_field("id", 32'(want.result_id), 32'(got.result_id));
        check_field("handle", 32'(want.result_handle), 32'(got.result_handle));
        check_field("family", 32'(want.result_family), 32'(got.result_family));
        check_field("last", 32'(want.last_item), 32'(got.last_item));
      end
      results_seen++;
    end
  end

  initial begin : stimulus
    logic [ID_W-1:0] phase_base;
    // every input known from time zero
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_kind            = KIND_ADD;
    in_client_id       = '0;
    in_os_handle       = '0;
    in_protocol_family = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    tx_idle_on         = 1'b1;
    rx_idle_on         = 1'b1;
    hold_request       = 1'b0;
    error_count        = 0;
    results_seen       = 0;
    base_now           = '0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      slot_used[i]   = 1'b0;
      slot_handle[i] = '0;
      slot_family[i] = 1'b0;
    end
    // handle pool: both extremes plus random values, so lookups can hit
    handle_pool[0] = '0;
    handle_pool[1] = ALL_ONES;
    for (int i = 2; i < 8; i++) handle_pool[i] = ID_W'($urandom);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_STEPS[i])
      send_item(DIRECTED_STEPS[i].cmd, DIRECTED_STEPS[i].typed, DIRECTED_STEPS[i].want);

    // each phase moves the window; stored entries keep their slots
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      settle();
      case (phase)
        0:       phase_base = ID_W'($urandom_range(1, 1000));
        1:       phase_base = BASE_ID_TOP;
        2:       phase_base = ID_W'($urandom_range(1001, int'(BASE_ID_TOP) - 1));
        default: phase_base = '0;
      endcase
      write_base_id(phase_base);
      // from the third phase the receiver takes every result; last phase runs flat out
      tx_idle_on = (phase < NUM_PHASES - 1);
      rx_idle_on = (phase < 2);

      // fill the table to the top, then two adds that must report full
      if (phase < 2) begin
        while (slots_in_use() < TABLE_SIZE) send_item(random_command_add(), 1'b0, NO_WANT);
        repeat (2) send_item(random_command_add(), 1'b0, NO_WANT);
      end
      // long receiver hold while items keep coming, so the input side backs up
      if (phase == 1) hold_request = ~hold_request;

      repeat (ITEMS_PER_PHASE) send_item(random_command(), 1'b0, NO_WANT);
    end
    settle();

    if (error_count == 0) begin
      $display("** client_id_registry: PASSED **");
    end else begin
      $display("** client_id_registry: FAILED **");
    end
    $finish;
  end

endmodule
